### hw/rtl/ut8s_pkg.sv
// Shared types, byte constants and decode helpers for the UTF-8 sanitizer.
// Used by ut8s_decode, ut8s_emit and the top level utf8_sanitizer.
package ut8s_pkg;

  // Maximum symbols one input beat can produce (each symbol is a
  // literal byte or a three-byte replacement character).
  localparam int MaxSyms = 4;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  // Lead byte ranges
  localparam logic [7:0] AsciiTop   = 8'h7F;
  localparam logic [7:0] Lead2Lo    = 8'hC2;
  localparam logic [7:0] Lead2Hi    = 8'hDF;
  localparam logic [7:0] Lead3Lo    = 8'hE0;
  localparam logic [7:0] Lead3Hi    = 8'hEF;
  localparam logic [7:0] Lead4Lo    = 8'hF0;
  localparam logic [7:0] Lead4Hi    = 8'hF4;

  // Second-byte limits for leads with restricted ranges
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] Limit3     = 8'hA0;
  localparam logic [7:0] Limit4     = 8'h90;

  // Continuation byte tag in the top two bits
  localparam logic [1:0] ContTag    = 2'b10;

  // Index of the final byte of a replacement character
  localparam logic [1:0] RepLastSub = 2'd2;

  typedef struct packed {
    logic       rep;    // 1: emit EF BF BD, 0: emit value
    logic [7:0] value;
  } sym_t;

  typedef struct packed {
    sym_t [MaxSyms-1:0] sym;
    logic [2:0]         count;
    logic               last;
  } plan_t;

  // Sequence length for a lead byte: 1 for ASCII, 2..4 for multi-byte
  // leads, 0 for a byte that can never start a character.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b <= AsciiTop) begin
      len = 3'd1;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      len = 3'd2;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      len = 3'd3;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte of the replacement character at position sub
  function automatic logic [7:0] rep_byte(input logic [1:0] sub);
    logic [7:0] b;
    case (sub)
      2'd0:    b = RepByte0;
      2'd1:    b = RepByte1;
      default: b = RepByte2;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/ut8s_decode.sv
// Sequence tracker for the UTF-8 sanitizer: holds the unfinished sequence
// and turns each input beat into a plan of output symbols. Uses ut8s_pkg.
module ut8s_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             accept,
  output ut8s_pkg::plan_t  plan
);

  logic [7:0] pend [3];
  logic [1:0] pc;
  logic [2:0] exp_len;

  logic [7:0] pend_next [3];
  logic [1:0] pc_next;
  logic [2:0] exp_len_next;

  logic [2:0] n;
  logic       cont_ok;
  logic       bad_second;
  logic       take_lead;
  logic [2:0] len_of_b;

  // Check the beat as a continuation of the buffered sequence
  always_comb begin
    bad_second = 1'b0;
    if (pc == 2'd1) begin
      bad_second = (pend[0] == ut8s_pkg::LeadE0 && in_byte <  ut8s_pkg::Limit3) ||
                   (pend[0] == ut8s_pkg::LeadED && in_byte >= ut8s_pkg::Limit3) ||
                   (pend[0] == ut8s_pkg::LeadF0 && in_byte <  ut8s_pkg::Limit4) ||
                   (pend[0] == ut8s_pkg::LeadF4 && in_byte >= ut8s_pkg::Limit4);
    end
    cont_ok  = (in_byte[7:6] == ut8s_pkg::ContTag) && !bad_second;
    len_of_b = ut8s_pkg::lead_len(in_byte);
  end

  // Build the symbol plan and the next sequence state
  always_comb begin
    plan         = '0;
    n            = 3'd0;
    pend_next    = pend;
    pc_next      = pc;
    exp_len_next = exp_len;
    take_lead    = 1'b0;

    if (pc == 2'd0) begin
      take_lead = 1'b1;
    end else if (cont_ok) begin
      if ({1'b0, pc} + 3'd1 >= exp_len) begin
        // complete sequence: release buffered bytes and this one
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < pc) begin
            plan.sym[n[1:0]] = '{rep: 1'b0, value: pend[i]};
            n = n + 3'd1;
          end
        end
        plan.sym[n[1:0]] = '{rep: 1'b0, value: in_byte};
        n            = n + 3'd1;
        pc_next      = 2'd0;
        exp_len_next = 3'd0;
      end else begin
        // hold the byte and wait for more
        case (pc)
          2'd1:    pend_next[1] = in_byte;
          2'd2:    pend_next[2] = in_byte;
          default: ;
        endcase
        pc_next = pc + 2'd1;
      end
    end else begin
      // broken sequence: one replacement per buffered byte
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pc) begin
          plan.sym[n[1:0]] = '{rep: 1'b1, value: 8'h00};
          n = n + 3'd1;
        end
      end
      pc_next      = 2'd0;
      exp_len_next = 3'd0;
      take_lead    = 1'b1;
    end

    // examine the beat as a new lead
    if (take_lead) begin
      if (len_of_b == 3'd1) begin
        plan.sym[n[1:0]] = '{rep: 1'b0, value: in_byte};
        n = n + 3'd1;
      end else if (len_of_b != 3'd0) begin
        pend_next[0] = in_byte;
        pc_next      = 2'd1;
        exp_len_next = len_of_b;
      end else begin
        plan.sym[n[1:0]] = '{rep: 1'b1, value: 8'h00};
        n = n + 3'd1;
      end
    end

    // end of stream: flush whatever is still pending
    if (in_last) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pc_next) begin
          plan.sym[n[1:0]] = '{rep: 1'b1, value: 8'h00};
          n = n + 3'd1;
        end
      end
      pc_next      = 2'd0;
      exp_len_next = 3'd0;
    end

    plan.count = n;
    plan.last  = in_last;
  end

  // Advance the sequence state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 2'd0;
      exp_len <= 3'd0;
    end else if (accept) begin
      pc      <= pc_next;
      exp_len <= exp_len_next;
    end
  end

  // Buffered bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
    end
  end

endmodule

### hw/rtl/ut8s_emit.sv
// Output sequencer for the UTF-8 sanitizer: holds one symbol plan and
// sends it out one byte per beat through an output register. Uses ut8s_pkg.
module ut8s_emit (
  input  logic             clk,
  input  logic             rst,
  input  ut8s_pkg::plan_t  plan_in,
  input  logic             plan_load,
  output logic             plan_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_replaced,
  output logic             out_last
);

  ut8s_pkg::plan_t plan;
  logic            plan_valid;
  logic [1:0]      sub;

  ut8s_pkg::sym_t  cur;
  logic            emit;
  logic            sym_end;
  logic            plan_end;
  logic [7:0]      byte_next;

  // Pick the next byte from the head symbol
  always_comb begin
    cur       = plan.sym[0];
    emit      = plan_valid && (!out_valid || out_ready);
    sym_end   = !cur.rep || (sub == ut8s_pkg::RepLastSub);
    plan_end  = sym_end && (plan.count == 3'd1);
    byte_next = cur.rep ? ut8s_pkg::rep_byte(sub) : cur.value;
    plan_free = !plan_valid || (emit && plan_end);
  end

  // Control: plan occupancy, position in replacement, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      sub        <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (sym_end) begin
          sub <= 2'd0;
          if (plan_end) begin
            plan_valid <= 1'b0;
          end
        end else begin
          sub <= sub + 2'd1;
        end
      end
      if (plan_load) begin
        plan_valid <= 1'b1;
        sub        <= 2'd0;
      end
    end
  end

  // Payload: load a new plan or drop the finished head symbol
  always_ff @(posedge clk) begin
    if (plan_load) begin
      plan <= plan_in;
    end else if (emit && sym_end) begin
      for (int i = 0; i < ut8s_pkg::MaxSyms - 1; i++) begin
        plan.sym[i] <= plan.sym[i+1];
      end
      plan.count <= plan.count - 3'd1;
    end
    if (emit) begin
      out_byte     <= byte_next;
      out_replaced <= cur.rep;
      out_last     <= plan.last && plan_end;
    end
  end

endmodule

### hw/rtl/utf8_sanitizer.sv
// UTF-8 sanitizer: byte stream in, well-formed UTF-8 out, with U+FFFD
// (EF BF BD) in place of each byte of a broken or disallowed sequence.
// Depends on ut8s_pkg, ut8s_decode and ut8s_emit.
//
// One input byte is taken per cycle whenever the output sequencer holds no
// plan, or is sending the final byte of its plan in that cycle; a byte that
// only extends an unfinished sequence leaves no plan behind. Output runs at
// one byte per cycle while out_ready is high, through a registered plan and
// an output register; the sequencer holds each plan until all of its output
// bytes are sent, 0 to 12 per input beat, typically 1 for clean text and 3
// for a replaced byte. The output port's one-byte-per-cycle rate sets the
// throughput. The final output byte of a stream carries out_last, and a
// beat marked in_last always yields at least one output byte.
module utf8_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_replaced,
  output logic       out_last
);

  ut8s_pkg::plan_t plan;
  logic            accept;
  logic            plan_free;
  logic            plan_load;

  // Accept a beat when the sequencer can take its plan
  assign in_ready  = plan_free;
  assign accept    = in_valid && in_ready;
  assign plan_load = accept && (plan.count != 3'd0);

  ut8s_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .in_last (in_last),
    .accept  (accept),
    .plan    (plan)
  );

  ut8s_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .plan_in      (plan),
    .plan_load    (plan_load),
    .plan_free    (plan_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_replaced (out_replaced),
    .out_last     (out_last)
  );

endmodule

### hw/rtl/ut8s_checker.sv
// Port-level checks for utf8_sanitizer, attached with a bind statement.
// Depends on ut8s_pkg for the replacement byte values.
module ut8s_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_replaced,
  input logic       out_last
);

  // Hold a stalled input beat
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input beat changed while stalled");

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_replaced) && $stable(out_last))
    else $error("output beat changed while stalled");

  // Replacement bytes are only EF, BF or BD
  a_rep_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_replaced |->
      (out_byte == ut8s_pkg::RepByte0 || out_byte == ut8s_pkg::RepByte1 ||
       out_byte == ut8s_pkg::RepByte2))
    else $error("replacement beat carries a foreign byte");

  // Passed-through bytes never include C0, C1 or F5..FF
  a_pass_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_replaced |->
      (out_byte[7:1] != 7'h60) && (out_byte < 8'hF5))
    else $error("invalid UTF-8 byte passed through");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_sanitizer ut8s_checker u_checker (.*);
